// ----- design/lla_pkg.sv -----
`default_nettype none
package lla_pkg;

  // field widths
  localparam int MODE_W      = 2;
  localparam int COORD_W     = 8;
  localparam int RULE_W      = 4;
  localparam int DIM_W       = 9;
  localparam int COUNT_W     = 17;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 9;

  // grid limits
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int NEIGHBORS      = 8;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GEN   = 2'd2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SURVIVE_MIN = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SURVIVE_MAX = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BIRTH_MIN   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BIRTH_MAX   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 3'd5;

  // rule bounds handed to every cell
  typedef struct packed {
    logic [RULE_W-1:0] survive_min;
    logic [RULE_W-1:0] survive_max;
    logic [RULE_W-1:0] birth_min;
    logic [RULE_W-1:0] birth_max;
  } rule_t;

  // per-cell tally bits moving down the chain
  typedef struct packed {
    logic died;
    logic alive;
  } tally_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_ROW,
    S_RMW,
    S_G_RD_N,
    S_G_RD_C,
    S_G_RD_S,
    S_G_LD_S,
    S_G_EVAL,
    S_G_SHIFT,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- design/lla_in_if.sv -----
`default_nettype none
interface lla_in_if;
  logic                             valid;
  logic                             ready;
  logic [lla_pkg::MODE_W-1:0]       mode;
  logic [lla_pkg::COORD_W-1:0]      cell_x;
  logic [lla_pkg::COORD_W-1:0]      cell_y;
  logic                             cell_value;

  modport source (output valid, mode, cell_x, cell_y, cell_value, input ready);
  modport sink   (input valid, mode, cell_x, cell_y, cell_value, output ready);
endinterface
`default_nettype wire

// ----- design/lla_out_if.sv -----
`default_nettype none
interface lla_out_if;
  logic                             valid;
  logic                             ready;
  logic                             read_value;
  logic [lla_pkg::COUNT_W-1:0]      died_count;
  logic [lla_pkg::COUNT_W-1:0]      alive_count;

  modport source (output valid, read_value, died_count, alive_count, input ready);
  modport sink   (input valid, read_value, died_count, alive_count, output ready);
endinterface
`default_nettype wire

// ----- design/life_like_automaton_generation_unit.sv -----
`default_nettype none
// Life-like automaton on a toroidal grid held as one memory row per grid row.
// Mode 0 writes a cell and mode 1 reads one. Mode 2 runs one generation: row by
// row, the rows north of, at and south of the current row sit in registers, a
// chain of MAX_WIDTH cells computes the new row at once and writes it back, and
// the died/alive tallies then shift down the chain one column a cycle. After
// reset a clearing pass zeroes the memory one row a cycle, during which no item
// is taken. Every item gives one result.
module life_like_automaton_generation_unit #(
  parameter int MAX_WIDTH  = lla_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lla_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  lla_in_if.sink                                  in_ch,
  lla_out_if.source                               out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [lla_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [lla_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = lla_pkg::COUNT_W;

  // configuration
  lla_pkg::rule_t                rules;
  logic [lla_pkg::DIM_W-1:0]     grid_width;
  logic [lla_pkg::DIM_W-1:0]     grid_height;
  logic [WW-1:0]                 eff_w;
  logic [HW-1:0]                 eff_h;
  logic [XW-1:0]                 w_last;
  logic [YW-1:0]                 h_last;

  lla_pkg::state_t state, state_next;

  // item and result
  logic [lla_pkg::MODE_W-1:0]    item_mode;
  logic [XW-1:0]                 item_x;
  logic [YW-1:0]                 item_y;
  logic                          item_value;
  logic                          res_read;
  logic [CW-1:0]                 res_died;
  logic [CW-1:0]                 res_alive;
  logic                          out_valid;
  logic [CW-1:0]                 out_died;
  logic [CW-1:0]                 out_alive;
  logic                          out_read;

  // generation datapath
  logic [YW-1:0]                 row;
  logic [XW-1:0]                 col_cnt;
  logic [YW-1:0]                 clr_addr;
  logic [MAX_WIDTH-1:0]          north_row;
  logic [MAX_WIDTH-1:0]          cur_row;
  logic [MAX_WIDTH-1:0]          south_row;
  logic [MAX_WIDTH-1:0]          row0_save;
  logic [MAX_WIDTH-1:0]          new_row;
  lla_pkg::tally_t               tally_q [MAX_WIDTH];
  logic                          last_row;
  logic [YW-1:0]                 south_addr;
  logic                          in_range;
  logic                          accept;
  logic                          out_load;

  // memory ports
  logic                          mem_we;
  logic [YW-1:0]                 mem_waddr;
  logic [MAX_WIDTH-1:0]          mem_wdata;
  logic [YW-1:0]                 mem_raddr;
  logic [MAX_WIDTH-1:0]          mem_rdata;

  // clamped grid size
  always_comb begin
    if (grid_width == '0) begin
      eff_w = WW'(1);
    end else if (int'(grid_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(grid_width);
    end
    if (grid_height == '0) begin
      eff_h = HW'(1);
    end else if (int'(grid_height) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(grid_height);
    end
    w_last     = XW'(int'(eff_w) - 1);
    h_last     = YW'(int'(eff_h) - 1);
    last_row   = (row == h_last);
    south_addr = last_row ? '0 : YW'(int'(row) + 1);
    in_range   = (int'(in_ch.cell_x) < int'(eff_w)) && (int'(in_ch.cell_y) < int'(eff_h));
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rules.survive_min <= lla_pkg::RULE_W'(2);
      rules.survive_max <= lla_pkg::RULE_W'(3);
      rules.birth_min   <= lla_pkg::RULE_W'(3);
      rules.birth_max   <= lla_pkg::RULE_W'(3);
      grid_width        <= lla_pkg::DIM_W'(256);
      grid_height       <= lla_pkg::DIM_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        lla_pkg::REG_SURVIVE_MIN: rules.survive_min <= cfg_data[lla_pkg::RULE_W-1:0];
        lla_pkg::REG_SURVIVE_MAX: rules.survive_max <= cfg_data[lla_pkg::RULE_W-1:0];
        lla_pkg::REG_BIRTH_MIN:   rules.birth_min   <= cfg_data[lla_pkg::RULE_W-1:0];
        lla_pkg::REG_BIRTH_MAX:   rules.birth_max   <= cfg_data[lla_pkg::RULE_W-1:0];
        lla_pkg::REG_GRID_WIDTH:  grid_width        <= cfg_data;
        lla_pkg::REG_GRID_HEIGHT: grid_height       <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state == lla_pkg::S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_load    = (state == lla_pkg::S_DONE) && (!out_valid || out_ch.ready);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lla_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory control
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = row;
    mem_wdata  = new_row;
    mem_raddr  = item_y;
    case (state)
      lla_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == YW'(MAX_HEIGHT - 1)) begin
          state_next = lla_pkg::S_IDLE;
        end
      end
      lla_pkg::S_IDLE: begin
        if (accept) begin
          if (in_ch.mode == lla_pkg::MODE_GEN) begin
            state_next = lla_pkg::S_G_RD_N;
          end else if ((in_ch.mode == lla_pkg::MODE_WRITE ||
                        in_ch.mode == lla_pkg::MODE_READ) && in_range) begin
            state_next = lla_pkg::S_RD_ROW;
          end else begin
            state_next = lla_pkg::S_DONE;
          end
        end
      end
      lla_pkg::S_RD_ROW: begin
        mem_raddr  = item_y;
        state_next = lla_pkg::S_RMW;
      end
      lla_pkg::S_RMW: begin
        mem_waddr = item_y;
        mem_wdata = mem_rdata;
        mem_wdata[item_x] = item_value;
        mem_we    = (item_mode == lla_pkg::MODE_WRITE);
        state_next = lla_pkg::S_DONE;
      end
      lla_pkg::S_G_RD_N: begin
        mem_raddr  = h_last;
        state_next = lla_pkg::S_G_RD_C;
      end
      lla_pkg::S_G_RD_C: begin
        mem_raddr  = '0;
        state_next = lla_pkg::S_G_RD_S;
      end
      lla_pkg::S_G_RD_S: begin
        mem_raddr  = south_addr;
        state_next = lla_pkg::S_G_LD_S;
      end
      lla_pkg::S_G_LD_S: begin
        state_next = lla_pkg::S_G_EVAL;
      end
      lla_pkg::S_G_EVAL: begin
        mem_we     = 1'b1;
        mem_waddr  = row;
        mem_wdata  = new_row;
        state_next = lla_pkg::S_G_SHIFT;
      end
      lla_pkg::S_G_SHIFT: begin
        if (col_cnt == w_last) begin
          state_next = last_row ? lla_pkg::S_DONE : lla_pkg::S_G_RD_S;
        end
      end
      lla_pkg::S_DONE: begin
        if (out_load) begin
          state_next = lla_pkg::S_IDLE;
        end
      end
      default: state_next = lla_pkg::S_IDLE;
    endcase
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == lla_pkg::S_CLEAR) begin
      clr_addr <= YW'(int'(clr_addr) + 1);
    end
  end

  // item, row buffers and tallies
  always_ff @(posedge clk) begin
    if (accept) begin
      item_mode  <= in_ch.mode;
      item_x     <= XW'(in_ch.cell_x);
      item_y     <= YW'(in_ch.cell_y);
      item_value <= in_ch.cell_value;
      res_read   <= 1'b0;
      res_died   <= '0;
      res_alive  <= '0;
      row        <= '0;
    end
    case (state)
      lla_pkg::S_RMW: begin
        if (item_mode == lla_pkg::MODE_READ) begin
          res_read <= mem_rdata[item_x];
        end
      end
      lla_pkg::S_G_RD_C: north_row <= mem_rdata;
      lla_pkg::S_G_RD_S: begin
        if (row == '0) begin
          cur_row   <= mem_rdata;
          row0_save <= mem_rdata;
        end
      end
      lla_pkg::S_G_LD_S: begin
        south_row <= (!last_row || row == '0) ? mem_rdata : row0_save;
      end
      lla_pkg::S_G_EVAL: col_cnt <= '0;
      lla_pkg::S_G_SHIFT: begin
        res_died  <= res_died + CW'(tally_q[0].died);
        res_alive <= res_alive + CW'(tally_q[0].alive);
        col_cnt   <= XW'(int'(col_cnt) + 1);
        if (col_cnt == w_last && !last_row) begin
          north_row <= cur_row;
          cur_row   <= south_row;
          row       <= YW'(int'(row) + 1);
        end
      end
      default: ;
    endcase
  end

  // row memory
  lla_ram #(
    .WIDTH (MAX_WIDTH),
    .DEPTH (MAX_HEIGHT)
  ) u_grid (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // chain of cells, one per column
  for (genvar x = 0; x < MAX_WIDTH; x++) begin : g_col
    logic            west_n, west_c, west_s;
    logic            east_n, east_c, east_s;
    lla_pkg::tally_t tally_in;

    if (x == 0) begin : g_west_edge
      assign west_n = north_row[w_last];
      assign west_c = cur_row[w_last];
      assign west_s = south_row[w_last];
    end else begin : g_west_inner
      assign west_n = north_row[x-1];
      assign west_c = cur_row[x-1];
      assign west_s = south_row[x-1];
    end

    if (x == MAX_WIDTH - 1) begin : g_east_edge
      assign east_n   = north_row[0];
      assign east_c   = cur_row[0];
      assign east_s   = south_row[0];
      assign tally_in = '0;
    end else begin : g_east_inner
      logic wrap_e;
      assign wrap_e   = (x + 1) >= int'(eff_w);
      assign east_n   = wrap_e ? north_row[0] : north_row[x+1];
      assign east_c   = wrap_e ? cur_row[0]   : cur_row[x+1];
      assign east_s   = wrap_e ? south_row[0] : south_row[x+1];
      assign tally_in = tally_q[x+1];
    end

    lla_cell u_cell (
      .clk        (clk),
      .active     (x < int'(eff_w)),
      .own        (cur_row[x]),
      .neigh      ({west_n, north_row[x], east_n, west_c,
                    east_c, west_s, south_row[x], east_s}),
      .rules      (rules),
      .load       (state == lla_pkg::S_G_EVAL),
      .shift      (state == lla_pkg::S_G_SHIFT),
      .tally_in   (tally_in),
      .next_value (new_row[x]),
      .tally      (tally_q[x])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_read  <= res_read;
      out_died  <= res_died;
      out_alive <= res_alive;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.read_value  = out_read;
  assign out_ch.died_count  = out_died;
  assign out_ch.alive_count = out_alive;

  // the tally shift never runs past the active width
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    state == lla_pkg::S_G_SHIFT |-> int'(col_cnt) < int'(eff_w))
    else $error("column counter beyond active width");

  // generation rows stay inside the active height
  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    state == lla_pkg::S_G_EVAL |-> int'(row) < int'(eff_h))
    else $error("row counter beyond active height");

  // a new result only follows the done state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(state) == lla_pkg::S_DONE)
    else $error("result raised outside done state");

endmodule
`default_nettype wire

// ----- design/lla_ram.sv -----
`default_nettype none
module lla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write, one registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- design/lla_cell.sv -----
`default_nettype none
module lla_cell (
  input  wire logic                              clk,
  input  wire logic                              active,
  input  wire logic                              own,
  input  wire logic [lla_pkg::NEIGHBORS-1:0]     neigh,
  input  wire lla_pkg::rule_t                    rules,
  input  wire logic                              load,
  input  wire logic                              shift,
  input  wire lla_pkg::tally_t                   tally_in,
  output logic                                   next_value,
  output lla_pkg::tally_t                        tally
);

  logic [lla_pkg::RULE_W-1:0] sum;
  logic                       rule_value;

  // neighbor count
  always_comb begin
    sum = '0;
    for (int i = 0; i < lla_pkg::NEIGHBORS; i++) begin
      sum = sum + lla_pkg::RULE_W'(neigh[i]);
    end
  end

  // survive or birth decision
  always_comb begin
    if (own) begin
      rule_value = (sum >= rules.survive_min) && (sum <= rules.survive_max);
    end else begin
      rule_value = (sum != '0) && (sum >= rules.birth_min) && (sum <= rules.birth_max);
    end
    next_value = active ? rule_value : own;
  end

  // tally stage of the chain
  always_ff @(posedge clk) begin
    if (load) begin
      tally.died  <= active & own & ~rule_value;
      tally.alive <= active & rule_value;
    end else if (shift) begin
      tally <= tally_in;
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/tb_life_like_automaton_generation_unit.sv -----
`timescale 1ns / 100ps
module tb_life_like_automaton_generation_unit;
  import lla_pkg::*;

  localparam int GRID_SIDE   = 256;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 12;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic               cell_value;
  } cell_op_t;

  typedef struct {
    logic               read_value;
    logic [COUNT_W-1:0] died_count;
    logic [COUNT_W-1:0] alive_count;
  } gen_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  lla_in_if  in_ch ();
  lla_out_if out_ch ();

  life_like_automaton_generation_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow copy of the grid and the rule registers
  bit cells [GRID_SIDE*GRID_SIDE];
  bit next_cells [GRID_SIDE*GRID_SIDE];
  logic [RULE_W-1:0] keep_lo, keep_hi, born_lo, born_hi;
  logic [DIM_W-1:0]  cols_reg, rows_reg;

  cell_op_t    pending_ops[$];
  gen_result_t expected_results[$];
  cell_op_t    cur_op;

  int errors = 0;
  int gens_run = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cycles = 0;
  int send_gap = 0;
  int recv_stall = 0;
  int hold_left = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  bit no_idle = 0;

  always #10 clk = ~clk;

  function automatic int clamp_dim(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > GRID_SIDE) return GRID_SIDE;
    return int'(v);
  endfunction

  function automatic int cell_at(int x, int y);
    return cells[y*GRID_SIDE + x];
  endfunction

  // one generation on the active area, returns died and alive tallies
  task automatic advance_grid(output logic [COUNT_W-1:0] died, output logic [COUNT_W-1:0] alive);
    int w, h, e, wv, n, s, nsum;
    bit nv;
    int d_cnt, a_cnt;
    w = clamp_dim(cols_reg);
    h = clamp_dim(rows_reg);
    d_cnt = 0;
    a_cnt = 0;
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        e  = (x + 1 < w) ? x + 1 : 0;
        wv = (x > 0) ? x - 1 : w - 1;
        n  = (y > 0) ? y - 1 : h - 1;
        s  = (y + 1 < h) ? y + 1 : 0;
        nsum = cell_at(e, y) + cell_at(wv, y) + cell_at(x, n) + cell_at(x, s)
             + cell_at(e, n) + cell_at(wv, n) + cell_at(e, s) + cell_at(wv, s);
        if (cell_at(x, y)) begin
          nv = (nsum >= keep_lo && nsum <= keep_hi);
          if (!nv) d_cnt++;
        end else begin
          nv = (nsum >= 1 && nsum >= born_lo && nsum <= born_hi);
        end
        if (nv) a_cnt++;
        next_cells[y*GRID_SIDE + x] = nv;
      end
    end
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        cells[y*GRID_SIDE + x] = next_cells[y*GRID_SIDE + x];
    died = COUNT_W'(d_cnt);
    alive = COUNT_W'(a_cnt);
  endtask

  // expected result of one accepted item
  task automatic predict_op(cell_op_t op);
    gen_result_t r;
    int w, h;
    w = clamp_dim(cols_reg);
    h = clamp_dim(rows_reg);
    r.read_value = 0;
    r.died_count = 0;
    r.alive_count = 0;
    case (op.mode)
      MODE_WRITE: begin
        if (op.cell_x < w && op.cell_y < h) cells[op.cell_y*GRID_SIDE + op.cell_x] = op.cell_value;
      end
      MODE_READ: begin
        if (op.cell_x < w && op.cell_y < h) r.read_value = 1'(cell_at(op.cell_x, op.cell_y));
      end
      MODE_GEN: begin
        advance_grid(r.died_count, r.alive_count);
        gens_run++;
      end
      default: ;
    endcase
    expected_results.insert(expected_results.size(), r);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
      $display("tb_life_like_automaton_generation_unit: FAIL");
      $finish;
    end
  end

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && !in_ch.ready)) begin
      if (in_ch.valid) begin
        predict_op(cur_op);
        items_sent++;
      end
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        cur_op = pending_ops.pop_front();
        in_ch.mode <= cur_op.mode;
        in_ch.cell_x <= cur_op.cell_x;
        in_ch.cell_y <= cur_op.cell_y;
        in_ch.cell_value <= cur_op.cell_value;
        in_ch.valid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side back-pressure, with one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1;
      hold_left = 400;
      out_ch.ready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      out_ch.ready <= 1'b0;
    end else if (no_idle) begin
      out_ch.ready <= 1'b1;
    end else begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        out_ch.ready <= 1'b1;
      end else begin
        recv_stall = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        out_ch.ready <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      gen_result_t exp_r;
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected: rd=%0d died=%0d alive=%0d", $time,
                 out_ch.read_value, out_ch.died_count, out_ch.alive_count);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_ch.read_value !== exp_r.read_value) begin
          $display("%0t: read_value expected %0d got %0d", $time, exp_r.read_value,
                   out_ch.read_value);
          errors++;
        end
        if (out_ch.died_count !== exp_r.died_count) begin
          $display("%0t: died_count expected %0d got %0d", $time, exp_r.died_count,
                   out_ch.died_count);
          errors++;
        end
        if (out_ch.alive_count !== exp_r.alive_count) begin
          $display("%0t: alive_count expected %0d got %0d", $time, exp_r.alive_count,
                   out_ch.alive_count);
          errors++;
        end
      end
    end
  end

  function automatic void queue_op(logic [MODE_W-1:0] m, int x, int y, bit v);
    cell_op_t op;
    op.mode = m;
    op.cell_x = COORD_W'(x);
    op.cell_y = COORD_W'(y);
    op.cell_value = v;
    pending_ops.insert(pending_ops.size(), op);
  endfunction

  task automatic set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_SURVIVE_MIN: keep_lo = val[RULE_W-1:0];
      REG_SURVIVE_MAX: keep_hi = val[RULE_W-1:0];
      REG_BIRTH_MIN:   born_lo = val[RULE_W-1:0];
      REG_BIRTH_MAX:   born_hi = val[RULE_W-1:0];
      REG_GRID_WIDTH:  cols_reg = val;
      REG_GRID_HEIGHT: rows_reg = val;
      default: ;
    endcase
  endtask

  task automatic set_rules(int s0, int s1, int b0, int b1, int w, int h);
    set_reg(REG_SURVIVE_MIN, CFG_DATA_W'(s0));
    set_reg(REG_SURVIVE_MAX, CFG_DATA_W'(s1));
    set_reg(REG_BIRTH_MIN, CFG_DATA_W'(b0));
    set_reg(REG_BIRTH_MAX, CFG_DATA_W'(b1));
    set_reg(REG_GRID_WIDTH, CFG_DATA_W'(w));
    set_reg(REG_GRID_HEIGHT, CFG_DATA_W'(h));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every item is sent and every result is back
  task automatic drain();
    do @(posedge clk);
    while (pending_ops.size() > 0 || in_ch.valid || expected_results.size() > 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // random items: mostly writes and reads inside the active area, some generations
  task automatic random_ops(int count);
    int w, h, r;
    w = clamp_dim(cols_reg);
    h = clamp_dim(rows_reg);
    for (int i = 0; i < count; i++) begin
      logic [MODE_W-1:0] m;
      int x, y;
      r = $urandom_range(0, 99);
      if (r < 45) m = MODE_WRITE;
      else if (r < 80) m = MODE_READ;
      else if (r < 94) m = MODE_GEN;
      else m = MODE_SPARE;
      if ($urandom_range(0, 99) < 80) begin
        x = $urandom_range(0, w - 1);
        y = $urandom_range(0, h - 1);
      end else begin
        x = $urandom_range(0, 255);
        y = $urandom_range(0, 255);
      end
      queue_op(m, x, y, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    clk = 0;
    rst = 1;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 0;
    in_ch.mode = MODE_WRITE;
    in_ch.cell_x = '0;
    in_ch.cell_y = '0;
    in_ch.cell_value = 0;
    out_ch.ready = 0;
    keep_lo = 2;
    keep_hi = 3;
    born_lo = 3;
    born_hi = 3;
    cols_reg = 256;
    rows_reg = 256;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // full-size grid: blinker across the east-west seam, corners, unused mode
    no_idle = 1;
    queue_op(MODE_WRITE, 255, 0, 1);
    queue_op(MODE_WRITE, 0, 0, 1);
    queue_op(MODE_WRITE, 1, 0, 1);
    queue_op(MODE_WRITE, 255, 255, 1);
    queue_op(MODE_WRITE, 255, 255, 0);
    queue_op(MODE_READ, 0, 0, 0);
    queue_op(MODE_READ, 128, 77, 1);
    queue_op(MODE_SPARE, 255, 255, 1);
    queue_op(MODE_GEN, 0, 0, 0);
    queue_op(MODE_READ, 0, 255, 0);
    queue_op(MODE_READ, 0, 1, 0);
    queue_op(MODE_READ, 1, 0, 0);
    queue_op(MODE_GEN, 255, 255, 1);
    queue_op(MODE_READ, 1, 0, 0);
    drain();
    no_idle = 0;

    // small life grid, with the long result hold-off during a write burst
    set_rules(2, 3, 3, 3, 8, 8);
    hold_req = 1;
    for (int i = 0; i < 10; i++) queue_op(MODE_WRITE, $urandom_range(0, 7), $urandom_range(0, 7), 1);
    random_ops(12);
    drain();

    // zero width acts as one column; wide-open rules
    set_rules(0, 8, 1, 8, 0, 2);
    queue_op(MODE_WRITE, 0, 1, 1);
    queue_op(MODE_GEN, 0, 0, 0);
    queue_op(MODE_READ, 0, 0, 0);
    random_ops(10);
    drain();

    // rule bounds at the top: everything dies, nothing born
    set_rules(15, 15, 0, 0, 2, 5);
    random_ops(14);
    drain();

    // oversize width acts as the full width; any count survives, any nonzero count gives birth
    set_rules(0, 15, 0, 15, 511, 3);
    queue_op(MODE_WRITE, 255, 2, 1);
    queue_op(MODE_GEN, 0, 0, 0);
    random_ops(12);
    drain();

    // full-width strip with the whole coordinate range
    no_idle = 1;
    set_rules(1, 4, 2, 6, 256, 4);
    random_ops(14);
    drain();
    no_idle = 0;

    // random rules on an odd grid
    set_rules($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
              $urandom_range(0, 15), 5, 7);
    random_ops(16);
    drain();

    $display("covered %0d items, %0d generations, %0d results over %0d cycles",
             items_sent, gens_run, results_seen, cycles);
    if (errors == 0) begin
      $display("tb_life_like_automaton_generation_unit: PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_life_like_automaton_generation_unit: FAIL");
    end
    $finish;
  end

endmodule
